// ----- rtl/isb_pkg.sv -----
// ----------------------------------------------------------------------------
// isb_pkg
// Shared widths, register indexes and pipeline geometry for the bisection
// square root block.
// ----------------------------------------------------------------------------
package isb_pkg;

  localparam int ROOT_BITS  = 16;
  localparam int VALUE_BITS = 32;
  localparam int SQ_BITS    = 2 * ROOT_BITS;
  localparam int CMP_BITS   = (SQ_BITS > VALUE_BITS) ? SQ_BITS : VALUE_BITS;
  localparam int CFG_IDX_BITS = 2;

  // Entry stage, then two stages per round (midpoint, square and compare).
  localparam int ROUNDS = ROOT_BITS;
  localparam int STAGES = 2 * ROUNDS + 1;

  localparam logic [ROOT_BITS-1:0] SEARCH_LOW_RST  = ROOT_BITS'(1);
  localparam logic [ROOT_BITS-1:0] SEARCH_HIGH_RST = ROOT_BITS'(10000);

  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_SEARCH_LOW  = CFG_IDX_BITS'(0),
    REG_SEARCH_HIGH = CFG_IDX_BITS'(1)
  } cfg_reg_e;

  typedef struct packed {
    logic [ROOT_BITS-1:0]  lo;
    logic [ROOT_BITS-1:0]  hi;
    logic [ROOT_BITS-1:0]  mid;
    logic [VALUE_BITS-1:0] mag;
    logic                  neg;
    logic                  go;
    logic                  done;
  } stage_t;

endpackage

// ----- rtl/isb_if.sv -----
// ----------------------------------------------------------------------------
// isb_if
// Valid/ready channels of the bisection square root block: input value,
// result root and register write.
// ----------------------------------------------------------------------------
interface isb_value_if;
  import isb_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [VALUE_BITS-1:0] value;
  modport source (output valid, output value, input ready);
  modport sink   (input valid, input value, output ready);
endinterface

interface isb_root_if;
  import isb_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [ROOT_BITS-1:0] root;
  modport source (output valid, output root, input ready);
  modport sink   (input valid, input root, output ready);
endinterface

interface isb_cfg_if;
  import isb_pkg::*;
  logic                    valid;
  logic                    ready;
  logic [CFG_IDX_BITS-1:0] index;
  logic [ROOT_BITS-1:0]    data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ----- rtl/integer_sqrt_bisection.sv -----
// ----------------------------------------------------------------------------
// integer_sqrt_bisection
// Integer square root of a signed word by bisection over the interval
// [search_low, search_high), one round per two pipeline stages.
// ----------------------------------------------------------------------------
//  channel   dir   payload                 handshake
//  value_i   in    value  (32b signed)     valid / ready
//  root_o    out   root   (16b unsigned)   valid / ready
//  cfg_i     in    index (2b), data (16b)  valid / ready, always ready
//
//  The pipeline holds one entry stage, then per round one midpoint stage and
//  one square-and-compare stage (16x16 multiplier).
//  Unless root_o stalls, a new word enters and one root leaves every cycle.
//  Reset sets search_low to 1, search_high to 10000 and empties the pipeline.
//  A stalled output freezes every stage; nothing is dropped or repeated.
// ----------------------------------------------------------------------------
module integer_sqrt_bisection (
  input  logic       clk_i,
  input  logic       rst_ni,
  isb_value_if.sink  value_i,
  isb_root_if.source root_o,
  isb_cfg_if.sink    cfg_i
);
  import isb_pkg::*;

  localparam int LAST = STAGES - 1;

  logic [ROOT_BITS-1:0] search_low_q;
  logic [ROOT_BITS-1:0] search_high_q;

  stage_t            st_q [STAGES];
  stage_t            st_d [STAGES];
  logic [LAST:0]     vld_q;
  logic              en;

  assign en            = !vld_q[LAST] || root_o.ready;
  assign value_i.ready = en;
  assign cfg_i.ready   = 1'b1;
  assign root_o.valid  = vld_q[LAST];
  assign root_o.root   = st_q[LAST].lo;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      search_low_q  <= SEARCH_LOW_RST;
      search_high_q <= SEARCH_HIGH_RST;
    end else if (cfg_i.valid) begin
      case (cfg_reg_e'(cfg_i.index))
        REG_SEARCH_LOW:  search_low_q  <= cfg_i.data;
        REG_SEARCH_HIGH: search_high_q <= cfg_i.data;
        default: ;
      endcase
    end
  end

  always_comb begin
    st_d[0]      = '0;
    st_d[0].lo   = search_low_q;
    st_d[0].hi   = search_high_q;
    st_d[0].mag  = value_i.value;
    st_d[0].neg  = value_i.value[VALUE_BITS-1];
  end

  for (genvar r = 0; r < ROUNDS; r++) begin : g_round
    logic [ROOT_BITS:0]   sum;
    logic [SQ_BITS-1:0]   sq;
    logic [CMP_BITS-1:0]  sq_ext;
    logic [CMP_BITS-1:0]  mag_ext;

    // Midpoint stage
    always_comb begin
      sum          = {1'b0, st_q[2*r].lo} + {1'b0, st_q[2*r].hi};
      st_d[2*r+1]  = st_q[2*r];
      st_d[2*r+1].mid = sum[ROOT_BITS:1];
      st_d[2*r+1].go  = !st_q[2*r].done &&
                        ({1'b0, st_q[2*r].hi} > ({1'b0, st_q[2*r].lo} + 1'b1));
    end

    // Square and compare stage
    always_comb begin
      sq      = SQ_BITS'(st_q[2*r+1].mid) * SQ_BITS'(st_q[2*r+1].mid);
      sq_ext  = CMP_BITS'(sq);
      mag_ext = CMP_BITS'(st_q[2*r+1].mag);
      st_d[2*r+2]    = st_q[2*r+1];
      st_d[2*r+2].go = 1'b0;
      if (!st_q[2*r+1].go) begin
        st_d[2*r+2].done = 1'b1;
      end else if (st_q[2*r+1].neg) begin
        st_d[2*r+2].hi = st_q[2*r+1].mid;
      end else if (sq_ext == mag_ext) begin
        st_d[2*r+2].lo   = st_q[2*r+1].mid;
        st_d[2*r+2].done = 1'b1;
      end else if (sq_ext < mag_ext) begin
        st_d[2*r+2].lo = st_q[2*r+1].mid;
      end else begin
        st_d[2*r+2].hi = st_q[2*r+1].mid;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[LAST-1:0], value_i.valid};
    end
  end

  for (genvar s = 0; s < STAGES; s++) begin : g_stage
    always_ff @(posedge clk_i) begin
      if (en) begin
        st_q[s] <= st_d[s];
      end
    end
  end

  a_word_enters: assert property (@(posedge clk_i) disable iff (!rst_ni)
    value_i.valid && value_i.ready |=> vld_q[0])
    else $error("accepted word missing from entry stage");

  a_stall_freezes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en |=> $stable(vld_q))
    else $error("pipeline moved during stall");

  a_interval_closed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[LAST] |-> st_q[LAST].done ||
                    ({1'b0, st_q[LAST].hi} <= ({1'b0, st_q[LAST].lo} + 1'b1)))
    else $error("search interval still open at output");

endmodule

// ----- tb/isb_root_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// isb_root_checker
// Watches the value, root and register channels of the bisection square root
// block. Tracks the search window, predicts one root per accepted value word
// and compares each accepted root word against the oldest prediction.
// ----------------------------------------------------------------------------
module isb_root_checker (
  input  logic  clk_i,
  input  logic  rst_ni,
  isb_value_if  value_mon_i,
  isb_root_if   root_mon_i,
  isb_cfg_if    cfg_mon_i,
  output int    fail_count_o,
  output int    pending_o
);
  import isb_pkg::*;

  logic [ROOT_BITS-1:0] search_low_q;
  logic [ROOT_BITS-1:0] search_high_q;
  logic [ROOT_BITS-1:0] root_expect_q [$];
  logic [ROOT_BITS-1:0] root_want;
  int                   mismatches = 0;

  assign fail_count_o = mismatches;

  function automatic logic [ROOT_BITS-1:0] bisect_root(
    input logic [VALUE_BITS-1:0] value,
    input logic [ROOT_BITS-1:0]  low_cfg,
    input logic [ROOT_BITS-1:0]  high_cfg
  );
    logic [ROOT_BITS:0]    lo;
    logic [ROOT_BITS:0]    hi;
    logic [ROOT_BITS:0]    mid;
    logic [CMP_BITS-1:0]   square;
    logic [CMP_BITS-1:0]   mag;
    logic                  neg;
    lo     = {1'b0, low_cfg};
    hi     = {1'b0, high_cfg};
    neg    = value[VALUE_BITS-1];
    mag    = CMP_BITS'(value);
    square = '0;
    while (hi > lo + 1) begin
      mid    = (lo + hi) >> 1;
      square = CMP_BITS'(mid[ROOT_BITS-1:0]) * CMP_BITS'(mid[ROOT_BITS-1:0]);
      if (!neg && square == mag) begin
        return mid[ROOT_BITS-1:0];
      end
      if (!neg && square < mag) begin
        lo = mid;
      end else begin
        hi = mid;
      end
    end
    return lo[ROOT_BITS-1:0];
  endfunction

  task automatic report_mismatch(input string msg);
    $display("[%0t] ERROR: %s", $realtime, msg);
    mismatches++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      search_low_q  <= SEARCH_LOW_RST;
      search_high_q <= SEARCH_HIGH_RST;
      root_expect_q.delete();
      pending_o     <= 0;
    end else begin
      if (root_mon_i.valid && root_mon_i.ready) begin
        if (root_expect_q.size() == 0) begin
          report_mismatch($sformatf("root word %0d with no value pending", root_mon_i.root));
        end else begin
          root_want = root_expect_q.pop_front();
          if (root_mon_i.root !== root_want) begin
            report_mismatch($sformatf("root %0d, predicted %0d", root_mon_i.root, root_want));
          end
        end
      end
      if (value_mon_i.valid && value_mon_i.ready) begin
        root_expect_q.push_back(bisect_root(value_mon_i.value, search_low_q, search_high_q));
      end
      if (cfg_mon_i.valid && cfg_mon_i.ready) begin
        case (cfg_mon_i.index)
          REG_SEARCH_LOW: begin
            search_low_q <= cfg_mon_i.data;
          end
          REG_SEARCH_HIGH: begin
            search_high_q <= cfg_mon_i.data;
          end
          default: begin
          end
        endcase
      end
      pending_o <= root_expect_q.size();
    end
  end

endmodule

// ----- tb/integer_sqrt_bisection_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// integer_sqrt_bisection_tb
// Drives value words and search window writes into the bisection square root
// block with random gaps and output stalls; a side checker predicts and
// compares every root word and the top reports the verdict.
// ----------------------------------------------------------------------------
module integer_sqrt_bisection_tb;
  import isb_pkg::*;

  localparam int IDLE_PCT        = 11;
  localparam int NUM_PHASES      = 13;
  localparam int WORDS_PER_PHASE = 110;
  localparam int QUIET_PHASE     = 4;
  localparam int DRAIN_CYCLES    = STAGES + 8;

  localparam logic [CFG_IDX_BITS-1:0] REG_SPARE_2 = CFG_IDX_BITS'(2);
  localparam logic [CFG_IDX_BITS-1:0] REG_SPARE_3 = CFG_IDX_BITS'(3);

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;
  logic quiet  = 1'b0;
  int   fail_count;
  int   pending;

  logic [VALUE_BITS-1:0] directed_words [$] = '{
    32'd0, 32'd1, 32'd2, 32'd3, 32'd4, 32'd15, 32'd16, 32'd17,
    32'd99980001, 32'd99999999, 32'd100000000, 32'd100000001,
    32'd2147395600, 32'd2147395599, 32'h7FFF_FFFF, 32'h8000_0000,
    32'hFFFF_FFFF, 32'h5555_5555, 32'hAAAA_AAAA, 32'h4000_0000
  };

  logic [2*ROOT_BITS-1:0] fixed_windows [$] = '{
    {16'd0, 16'hFFFF}, {16'd0, 16'd0}, {16'hFFFF, 16'hFFFF}, {16'hFFFF, 16'd0},
    {16'd100, 16'd101}, {16'd46339, 16'd46342}, {16'd0, 16'd1}, {16'd1, 16'd2}
  };

  isb_value_if value_ch ();
  isb_root_if  root_ch ();
  isb_cfg_if   cfg_ch ();

  integer_sqrt_bisection dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .value_i (value_ch),
    .root_o  (root_ch),
    .cfg_i   (cfg_ch)
  );

  isb_root_checker u_check (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .value_mon_i  (value_ch),
    .root_mon_i   (root_ch),
    .cfg_mon_i    (cfg_ch),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  initial begin
    #2_000_000;
    $display("Some tests failed");
    $finish;
  end

  initial begin
    root_ch.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      root_ch.ready = quiet || ($urandom_range(99) >= IDLE_PCT);
    end
  end

  function automatic logic [VALUE_BITS-1:0] pick_value(
    input logic [ROOT_BITS-1:0] lo,
    input logic [ROOT_BITS-1:0] hi
  );
    logic [VALUE_BITS-1:0] r;
    logic [VALUE_BITS-1:0] square;
    case ($urandom_range(9))
      0, 1: begin
        return $urandom;
      end
      2: begin
        return $urandom | 32'h8000_0000;
      end
      3: begin
        return $urandom_range(300);
      end
      default: begin
        r = (hi > lo) ? $urandom_range(hi, lo) : $urandom_range(65535);
        square = r * r;
        return square + VALUE_BITS'($urandom_range(2)) - 1;
      end
    endcase
  endfunction

  task automatic pick_window(output logic [ROOT_BITS-1:0] lo, output logic [ROOT_BITS-1:0] hi);
    case ($urandom_range(2))
      0: begin
        lo = ROOT_BITS'($urandom_range(200));
        hi = ROOT_BITS'($urandom_range(65535, 1000));
      end
      1: begin
        lo = ROOT_BITS'($urandom);
        hi = ROOT_BITS'($urandom);
      end
      default: begin
        lo = ROOT_BITS'($urandom_range(46000));
        hi = lo + ROOT_BITS'($urandom_range(40));
      end
    endcase
  endtask

  task automatic send_value(input logic [VALUE_BITS-1:0] word);
    while (!quiet && $urandom_range(99) < IDLE_PCT) begin
      @(negedge clk_i);
    end
    value_ch.valid = 1'b1;
    value_ch.value = word;
    @(posedge clk_i);
    while (!value_ch.ready) begin
      @(posedge clk_i);
    end
    @(negedge clk_i);
    value_ch.valid = 1'b0;
  endtask

  task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx, input logic [ROOT_BITS-1:0] data);
    cfg_ch.valid = 1'b1;
    cfg_ch.index = idx;
    cfg_ch.data  = data;
    @(posedge clk_i);
    while (!cfg_ch.ready) begin
      @(posedge clk_i);
    end
    @(negedge clk_i);
    cfg_ch.valid = 1'b0;
  endtask

  task automatic wait_drained();
    while (pending != 0) begin
      @(negedge clk_i);
    end
  endtask

  initial begin : stimulus
    logic [ROOT_BITS-1:0] lo;
    logic [ROOT_BITS-1:0] hi;
    value_ch.valid = 1'b0;
    value_ch.value = '0;
    cfg_ch.valid   = 1'b0;
    cfg_ch.index   = REG_SEARCH_LOW;
    cfg_ch.data    = '0;
    repeat (7) @(negedge clk_i);
    rst_ni = 1'b1;
    lo = SEARCH_LOW_RST;
    hi = SEARCH_HIGH_RST;
    foreach (directed_words[k]) begin
      send_value(directed_words[k]);
    end
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      if (ph == 1) begin
        wait_drained();
        write_reg(REG_SPARE_2, ROOT_BITS'($urandom));
        write_reg(REG_SPARE_3, ROOT_BITS'($urandom));
      end else if (ph > 1) begin
        wait_drained();
        if (ph - 2 < fixed_windows.size()) begin
          {lo, hi} = fixed_windows[ph-2];
        end else begin
          pick_window(lo, hi);
        end
        if ($urandom_range(1) == 0) begin
          write_reg(REG_SEARCH_LOW, lo);
          write_reg(REG_SEARCH_HIGH, hi);
        end else begin
          write_reg(REG_SEARCH_HIGH, hi);
          write_reg(REG_SEARCH_LOW, lo);
        end
      end
      quiet = (ph == QUIET_PHASE);
      for (int i = 0; i < WORDS_PER_PHASE; i++) begin
        send_value(pick_value(lo, hi));
      end
    end
    quiet = 1'b0;
    wait_drained();
    repeat (DRAIN_CYCLES) @(negedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// ----- integer_sqrt_bisection.f -----
rtl/isb_pkg.sv
rtl/isb_if.sv
rtl/integer_sqrt_bisection.sv
tb/isb_root_checker.sv
tb/integer_sqrt_bisection_tb.sv
